>>> hw/rtl/vt52_to_ansi_translator_core_assert.svh
// Assertion macros of the port checker of the VT52 to ANSI translator.
`ifndef VT52_TO_ANSI_TRANSLATOR_CORE_ASSERT_SVH
`define VT52_TO_ANSI_TRANSLATOR_CORE_ASSERT_SVH

// Next-cycle implication that is also checked while reset is high.
`define VT52A_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("vt52a port check failed");

// Next-cycle implication that is switched off during reset.
`define VT52A_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vt52a port check failed");

`endif

>>> hw/rtl/vt52a_pkg.sv
// Shared types, constants and string tables of the VT52 to ANSI translator.
package vt52a_pkg;

   localparam int CMD_FIFO_DEPTH = 4;

   localparam logic [7:0] CHAR_ESC = 8'h1b;

   // Command kinds passed from the decoder to the expander.
   localparam logic [2:0] K_BYTE = 3'd0;
   localparam logic [2:0] K_ESC1 = 3'd1;
   localparam logic [2:0] K_ESC2 = 3'd2;
   localparam logic [2:0] K_STR  = 3'd3;
   localparam logic [2:0] K_CUP  = 3'd4;

   // Fixed output strings.
   localparam logic [4:0] S_RUBOUT    = 5'd0;
   localparam logic [4:0] S_CLEAR     = 5'd1;
   localparam logic [4:0] S_HOME      = 5'd2;
   localparam logic [4:0] S_INS_LINE  = 5'd3;
   localparam logic [4:0] S_DEL_LINE  = 5'd4;
   localparam logic [4:0] S_ERASE_EOL = 5'd5;
   localparam logic [4:0] S_FLASH     = 5'd6;
   localparam logic [4:0] S_REV_ON    = 5'd7;
   localparam logic [4:0] S_BOLD_ON   = 5'd8;
   localparam logic [4:0] S_BLINK_ON  = 5'd9;
   localparam logic [4:0] S_UL_ON     = 5'd10;
   localparam logic [4:0] S_CUR_ON    = 5'd11;
   localparam logic [4:0] S_SAVE      = 5'd12;
   localparam logic [4:0] S_REV_OFF   = 5'd13;
   localparam logic [4:0] S_ATTR_OFF  = 5'd14;
   localparam logic [4:0] S_BLINK_OFF = 5'd15;
   localparam logic [4:0] S_UL_OFF    = 5'd16;
   localparam logic [4:0] S_CUR_OFF   = 5'd17;
   localparam logic [4:0] S_RESTORE   = 5'd18;

   // One printed coordinate: up to three characters, left aligned.
   typedef struct packed {
      logic [1:0] len;
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
   } coord_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [4:0] str_sel;
      logic [7:0] ch;
      logic [7:0] prefix;
      coord_type  row;
      coord_type  col;
      logic [3:0] len;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   // Strings are left aligned in ten bytes; unused bytes are zero.
   function automatic logic [79:0] str_text(input logic [4:0] sel);
      logic [79:0] t;
      case (sel)
         S_RUBOUT:    t = {"\010 \010", 56'h0};
         S_CLEAR:     t = {"\033[H\033[2J", 24'h0};
         S_HOME:      t = {"\033[H", 56'h0};
         S_INS_LINE:  t = {"\033[L", 56'h0};
         S_DEL_LINE:  t = {"\033[M", 56'h0};
         S_ERASE_EOL: t = {"\033[K", 56'h0};
         S_FLASH:     t = "\033[?5h\033[?5l";
         S_REV_ON:    t = {"\033[7m", 48'h0};
         S_BOLD_ON:   t = {"\033[1m", 48'h0};
         S_BLINK_ON:  t = {"\033[5m", 48'h0};
         S_UL_ON:     t = {"\033[4m", 48'h0};
         S_CUR_ON:    t = {"\033[?25h", 32'h0};
         S_SAVE:      t = {"\033[s", 56'h0};
         S_REV_OFF:   t = {"\033[27m", 40'h0};
         S_ATTR_OFF:  t = {"\033[m", 56'h0};
         S_BLINK_OFF: t = {"\033[25m", 40'h0};
         S_UL_OFF:    t = {"\033[24m", 40'h0};
         S_CUR_OFF:   t = {"\033[?25l", 32'h0};
         S_RESTORE:   t = {"\033[u", 56'h0};
         default:     t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [3:0] str_len(input logic [4:0] sel);
      logic [3:0] n;
      case (sel)
         S_CLEAR:     n = 4'd7;
         S_FLASH:     n = 4'd10;
         S_REV_ON,
         S_BOLD_ON,
         S_BLINK_ON,
         S_UL_ON:     n = 4'd4;
         S_CUR_ON,
         S_CUR_OFF:   n = 4'd6;
         S_REV_OFF,
         S_BLINK_OFF,
         S_UL_OFF:    n = 4'd5;
         default:     n = 4'd3;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] str_byte(input logic [4:0] sel, input logic [3:0] idx);
      logic [79:0] t;
      logic [6:0]  top;
      t   = str_text(sel);
      top = 7'd79 - {idx, 3'b000};
      return t[top -: 8];
   endfunction

   function automatic logic [7:0] coord_char(input coord_type cd, input logic [1:0] j);
      logic [7:0] b;
      case (j)
         2'd0:    b = cd.c0;
         2'd1:    b = cd.c1;
         default: b = cd.c2;
      endcase
      return b;
   endfunction

endpackage

>>> hw/rtl/vt52_to_ansi_translator_core.sv
// Top level of the VT52 / ADM-3A to ANSI escape translator.
//
//   Port group  Direction  Handshake          Payload
//   req_        in         req_valid/stall    req_char_in
//   rsp_        out        rsp_valid/stall    rsp_out_byte, rsp_last_of_run
//   csr_        in         csr_wr_en          csr_wr_data (bell flash enable)
//
// The decoder takes one input byte per cycle while the command queue has room.
// The expander sends one output byte per cycle unless the output stalls; an input
// expands to a single output byte or to more than one, up to ten.
// The first output byte of an input passes through the queue, the current command and the output register.
// Synchronous reset returns the escape mode to plain text and empties the queue.
// An output stall holds the output register; the queue then fills and stalls the input.

module vt52_to_ansi_translator_core #(
   parameter int FIFO_DEPTH = vt52a_pkg::CMD_FIFO_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   vt52a_pkg::fifo_stat_type fifo_stat;
   vt52a_pkg::cmd_type       push_cmd;
   vt52a_pkg::cmd_type       head_cmd;
   logic                     push;
   logic                     pop;

   vt52a_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_char_in (req_char_in),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fifo_stat   (fifo_stat),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   vt52a_cmd_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (fifo_stat)
   );

   vt52a_back u_back (
      .clock           (clock),
      .reset           (reset),
      .fifo_stat       (fifo_stat),
      .head_cmd        (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

>>> hw/rtl/vt52a_front.sv
// Decoder front end: tracks the escape mode and turns input bytes into commands; some bytes emit none.
module vt52a_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_char_in,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   input  vt52a_pkg::fifo_stat_type fifo_stat,
   output logic                    push,
   output vt52a_pkg::cmd_type      push_cmd
);

   localparam logic [3:0] M_PLAIN    = 4'd0;
   localparam logic [3:0] M_ESC      = 4'd1;
   localparam logic [3:0] M_ROW      = 4'd2;
   localparam logic [3:0] M_COL      = 4'd3;
   localparam logic [3:0] M_ATTR_ON  = 4'd4;
   localparam logic [3:0] M_ATTR_OFF = 4'd5;
   localparam logic [3:0] M_ARG_A    = 4'd6;
   localparam logic [3:0] M_ARG_B    = 4'd7;
   localparam logic [3:0] M_ARG_C    = 4'd8;

   logic [3:0] mode_ff, mode_in;
   logic [7:0] row_ff, row_in;
   logic       flash_ff, flash_in;
   logic       accept;
   logic       emit;
   logic [2:0] kind;
   logic [4:0] sel;
   vt52a_pkg::coord_type row_cd, col_cd;

   // Prints byte - 31 as signed decimal without leading zeros.
   function automatic vt52a_pkg::coord_type to_coord(input logic [7:0] b);
      vt52a_pkg::coord_type cd;
      logic        neg;
      logic [7:0]  mag;
      logic [1:0]  hund;
      logic [7:0]  rem8;
      logic [6:0]  rem;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [3:0]  ones;
      logic [7:0]  ch_h, ch_t, ch_o;
      neg = (b < 8'd31);
      mag = neg ? (8'd31 - b) : (b - 8'd31);
      if (mag >= 8'd200) begin
         hund = 2'd2;
         rem8 = mag - 8'd200;
      end else if (mag >= 8'd100) begin
         hund = 2'd1;
         rem8 = mag - 8'd100;
      end else begin
         hund = 2'd0;
         rem8 = mag;
      end
      rem = rem8[6:0];
      // Multiply by the reciprocal of ten; exact for values below 100.
      prod     = {8'h00, rem} * 15'd205;
      tens     = prod[14:11];
      tens_x10 = {3'b000, tens} * 7'd10;
      ones     = 4'(rem - tens_x10);
      ch_h = 8'h30 + {6'h00, hund};
      ch_t = 8'h30 + {4'h0, tens};
      ch_o = 8'h30 + {4'h0, ones};
      cd = '0;
      if (neg) begin
         cd.c0 = "-";
         if (tens != 4'd0) begin
            cd.len = 2'd3;
            cd.c1  = ch_t;
            cd.c2  = ch_o;
         end else begin
            cd.len = 2'd2;
            cd.c1  = ch_o;
         end
      end else if (hund != 2'd0) begin
         cd.len = 2'd3;
         cd.c0  = ch_h;
         cd.c1  = ch_t;
         cd.c2  = ch_o;
      end else if (tens != 4'd0) begin
         cd.len = 2'd2;
         cd.c0  = ch_t;
         cd.c1  = ch_o;
      end else begin
         cd.len = 2'd1;
         cd.c0  = ch_o;
      end
      return cd;
   endfunction

   assign accept    = req_valid && !fifo_stat.full;
   assign req_stall = fifo_stat.full;
   assign row_cd    = to_coord(row_ff);
   assign col_cd    = to_coord(req_char_in);
   assign flash_in  = csr_wr_en ? csr_wr_data : flash_ff;

   always_comb begin
      mode_in = mode_ff;
      row_in  = row_ff;
      emit    = 1'b0;
      kind    = vt52a_pkg::K_BYTE;
      sel     = vt52a_pkg::S_RUBOUT;
      if (accept) begin
         case (mode_ff)
            M_PLAIN: begin
               if (req_char_in == 8'h07 && flash_ff) begin
                  emit = 1'b1;
                  kind = vt52a_pkg::K_STR;
                  sel  = vt52a_pkg::S_FLASH;
               end else begin
                  case (req_char_in)
                     8'h7f: begin
                        emit = 1'b1;
                        kind = vt52a_pkg::K_STR;
                        sel  = vt52a_pkg::S_RUBOUT;
                     end
                     8'h1a, 8'h0c: begin
                        emit = 1'b1;
                        kind = vt52a_pkg::K_STR;
                        sel  = vt52a_pkg::S_CLEAR;
                     end
                     8'h1e: begin
                        emit = 1'b1;
                        kind = vt52a_pkg::K_STR;
                        sel  = vt52a_pkg::S_HOME;
                     end
                     8'h1b: mode_in = M_ESC;
                     8'h01: mode_in = M_ROW;
                     8'h02: begin
                        emit = 1'b1;
                        kind = vt52a_pkg::K_STR;
                        sel  = vt52a_pkg::S_INS_LINE;
                     end
                     8'h03: begin
                        emit = 1'b1;
                        kind = vt52a_pkg::K_STR;
                        sel  = vt52a_pkg::S_DEL_LINE;
                     end
                     8'h18, 8'h05: begin
                        emit = 1'b1;
                        kind = vt52a_pkg::K_STR;
                        sel  = vt52a_pkg::S_ERASE_EOL;
                     end
                     8'h12, 8'h13: emit = 1'b0;
                     default: begin
                        emit = 1'b1;
                        kind = vt52a_pkg::K_BYTE;
                     end
                  endcase
               end
            end
            M_ESC: begin
               case (req_char_in)
                  8'h1b: begin
                     emit = 1'b1;
                     kind = vt52a_pkg::K_BYTE;
                  end
                  "=", "Y": mode_in = M_ROW;
                  "E": begin
                     emit = 1'b1;
                     kind = vt52a_pkg::K_STR;
                     sel  = vt52a_pkg::S_INS_LINE;
                  end
                  "R": begin
                     emit = 1'b1;
                     kind = vt52a_pkg::K_STR;
                     sel  = vt52a_pkg::S_DEL_LINE;
                  end
                  "B": mode_in = M_ATTR_ON;
                  "C": mode_in = M_ATTR_OFF;
                  "L", "D": mode_in = M_ARG_A;
                  "*", " ": mode_in = M_ARG_C;
                  default: begin
                     mode_in = M_PLAIN;
                     emit    = 1'b1;
                     kind    = vt52a_pkg::K_ESC1;
                  end
               endcase
            end
            M_ROW: begin
               row_in  = req_char_in;
               mode_in = M_COL;
            end
            M_COL: begin
               mode_in = M_PLAIN;
               emit    = 1'b1;
               kind    = vt52a_pkg::K_CUP;
            end
            M_ATTR_ON: begin
               mode_in = M_PLAIN;
               emit    = 1'b1;
               kind    = vt52a_pkg::K_STR;
               case (req_char_in)
                  "0": sel = vt52a_pkg::S_REV_ON;
                  "1": sel = vt52a_pkg::S_BOLD_ON;
                  "2": sel = vt52a_pkg::S_BLINK_ON;
                  "3": sel = vt52a_pkg::S_UL_ON;
                  "4": sel = vt52a_pkg::S_CUR_ON;
                  "6": sel = vt52a_pkg::S_SAVE;
                  "5", "7": emit = 1'b0;
                  default: kind = vt52a_pkg::K_ESC2;
               endcase
            end
            M_ATTR_OFF: begin
               mode_in = M_PLAIN;
               emit    = 1'b1;
               kind    = vt52a_pkg::K_STR;
               case (req_char_in)
                  "0": sel = vt52a_pkg::S_REV_OFF;
                  "1": sel = vt52a_pkg::S_ATTR_OFF;
                  "2": sel = vt52a_pkg::S_BLINK_OFF;
                  "3": sel = vt52a_pkg::S_UL_OFF;
                  "4": sel = vt52a_pkg::S_CUR_OFF;
                  "6": sel = vt52a_pkg::S_RESTORE;
                  "5", "7": emit = 1'b0;
                  default: kind = vt52a_pkg::K_ESC2;
               endcase
            end
            M_ARG_A, M_ARG_B, M_ARG_C: mode_in = mode_ff + 4'd1;
            default: mode_in = M_PLAIN;
         endcase
      end
   end

   always_comb begin
      push_cmd         = '0;
      push_cmd.kind    = kind;
      push_cmd.str_sel = sel;
      push_cmd.ch      = req_char_in;
      push_cmd.prefix  = (mode_ff == M_ATTR_ON) ? 8'h42 : 8'h43;
      push_cmd.row     = row_cd;
      push_cmd.col     = col_cd;
      case (kind)
         vt52a_pkg::K_BYTE: push_cmd.len = 4'd1;
         vt52a_pkg::K_ESC1: push_cmd.len = 4'd2;
         vt52a_pkg::K_ESC2: push_cmd.len = 4'd3;
         vt52a_pkg::K_STR:  push_cmd.len = vt52a_pkg::str_len(sel);
         vt52a_pkg::K_CUP:  push_cmd.len = 4'd4 + {2'b00, row_cd.len} + {2'b00, col_cd.len};
         default:           push_cmd.len = 4'd1;
      endcase
   end

   assign push = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_PLAIN;
         flash_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         flash_ff <= flash_in;
      end
      row_ff <= row_in;
   end

endmodule

>>> hw/rtl/vt52a_cmd_fifo.sv
// Short command queue between the decoder and the byte expander.
module vt52a_cmd_fifo #(
   parameter int DEPTH = vt52a_pkg::CMD_FIFO_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  vt52a_pkg::cmd_type       push_cmd,
   input  logic                     pop,
   output vt52a_pkg::cmd_type       head_cmd,
   output vt52a_pkg::fifo_stat_type stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   vt52a_pkg::cmd_type entries [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head_cmd   = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> hw/rtl/vt52a_back.sv
// Byte expander: walks each queued command and sends its bytes through an output register.
module vt52a_back (
   input  logic                     clock,
   input  logic                     reset,
   input  vt52a_pkg::fifo_stat_type fifo_stat,
   input  vt52a_pkg::cmd_type       head_cmd,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last_of_run
);

   vt52a_pkg::cmd_type cur_ff, cur_in;
   logic       cur_vld_ff, cur_vld_in;
   logic [3:0] idx_ff, idx_in;
   logic       out_vld_ff, out_vld_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_free;
   logic       emit;
   logic       is_last;
   logic       cur_done;
   logic [7:0] cur_byte;

   function automatic logic [7:0] byte_at(input vt52a_pkg::cmd_type cmd, input logic [3:0] i);
      logic [7:0] b;
      logic [3:0] semi;
      logic [3:0] col_end;
      logic [3:0] rel;
      semi    = 4'd2 + {2'b00, cmd.row.len};
      col_end = semi + 4'd1 + {2'b00, cmd.col.len};
      rel     = 4'd0;
      case (cmd.kind)
         vt52a_pkg::K_BYTE: b = cmd.ch;
         vt52a_pkg::K_ESC1: b = (i == 4'd0) ? vt52a_pkg::CHAR_ESC : cmd.ch;
         vt52a_pkg::K_ESC2: begin
            case (i)
               4'd0:    b = vt52a_pkg::CHAR_ESC;
               4'd1:    b = cmd.prefix;
               default: b = cmd.ch;
            endcase
         end
         vt52a_pkg::K_STR: b = vt52a_pkg::str_byte(cmd.str_sel, i);
         vt52a_pkg::K_CUP: begin
            // Layout is ESC [ row ; col H with variable-length row and column text.
            if (i == 4'd0) begin
               b = vt52a_pkg::CHAR_ESC;
            end else if (i == 4'd1) begin
               b = "[";
            end else if (i < semi) begin
               rel = i - 4'd2;
               b   = vt52a_pkg::coord_char(cmd.row, rel[1:0]);
            end else if (i == semi) begin
               b = ";";
            end else if (i < col_end) begin
               rel = i - semi - 4'd1;
               b   = vt52a_pkg::coord_char(cmd.col, rel[1:0]);
            end else begin
               b = "H";
            end
         end
         default: b = cmd.ch;
      endcase
      return b;
   endfunction

   assign out_free = !out_vld_ff || !rsp_stall;
   assign emit     = out_free && cur_vld_ff;
   assign is_last  = (idx_ff == cur_ff.len - 4'd1);
   assign cur_done = emit && is_last;
   assign pop      = !fifo_stat.empty && (!cur_vld_ff || cur_done);
   assign cur_byte = byte_at(cur_ff, idx_ff);

   always_comb begin
      cur_in      = cur_ff;
      cur_vld_in  = cur_vld_ff;
      idx_in      = idx_ff;
      out_vld_in  = out_vld_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      if (pop) begin
         cur_in     = head_cmd;
         cur_vld_in = 1'b1;
         idx_in     = 4'd0;
      end else if (cur_done) begin
         cur_vld_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 4'd1;
      end
      if (out_free) begin
         out_vld_in  = emit;
         out_byte_in = cur_byte;
         out_last_in = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         cur_vld_ff <= cur_vld_in;
         out_vld_ff <= out_vld_in;
      end
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

>>> hw/rtl/vt52a_port_checker.sv
// Port-level checker of the translator and its bind to the top level.
`include "vt52_to_ansi_translator_core_assert.svh"

module vt52a_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run
);

   // Reset empties both the queue and the output register.
   `VT52A_ASSERT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid && !req_stall)

   // A stalled result keeps its byte and its end marker.
   `VT52A_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last_of_run))

   // Bytes of one run follow each other without a gap.
   `VT52A_ASSERT_NEXT(a_run_unbroken, clock, reset, rsp_valid && !rsp_stall && !rsp_last_of_run, rsp_valid)

endmodule

bind vt52_to_ansi_translator_core vt52a_port_checker u_port_checker (.*);
